@@ src/sha_pkg.sv @@
// Shared types, queue sizing and SHA-256 constant tables for the message hasher.
`default_nettype none

package sha_pkg;

  // Word queue between the byte packer and the compression engine.
  localparam int QDEPTH = 16;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // One big-endian message word on its way to the compression engine.
  typedef struct packed {
    logic        msg_end;   // Last word of the final padded block of a message.
    logic        too_long;  // Byte count saturated; meaningful with msg_end.
    logic [31:0] word;
  } q_entry_t;

  typedef enum logic {
    FR_ACCEPT,
    FR_PAD
  } front_state_t;

  typedef enum logic [1:0] {
    BK_ROUND,
    BK_ADD,
    BK_OUT
  } back_state_t;

  function automatic logic [31:0] iv_word(input logic [2:0] i);
    logic [31:0] v;
    case (i)
      3'd0:    v = 32'h6a09e667;
      3'd1:    v = 32'hbb67ae85;
      3'd2:    v = 32'h3c6ef372;
      3'd3:    v = 32'ha54ff53a;
      3'd4:    v = 32'h510e527f;
      3'd5:    v = 32'h9b05688c;
      3'd6:    v = 32'h1f83d9ab;
      3'd7:    v = 32'h5be0cd19;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] v;
    case (i)
      6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
      6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
      6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
      6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
      6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
      6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
      6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
      6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
      6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
      6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
      6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
      6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
      6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
      6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
      6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
      6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
      6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
      6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
      6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
      6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
      6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
      6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
      6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
      6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
      6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
      6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
      6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
      6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
      6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
      6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
      6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
      6'd62: v = 32'hbef9a3f7;  6'd63: v = 32'hc67178f2;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ src/sha_front.sv @@
// Byte packer and padding generator that feeds message words into the word queue.
`default_nettype none

module sha_front
  import sha_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic     has_byte,
  input  wire logic     last,
  output logic          push,
  output q_entry_t      push_entry,
  input  wire logic     q_full
);

  front_state_t state, state_next;
  logic [31:0]  byte_count;
  logic         overflow;
  logic [23:0]  acc;
  logic [3:0]   pw;
  logic         pad_first;
  logic         len_here;

  logic        beat;
  logic        saturated;
  logic        take_byte;
  logic [31:0] count_after;
  logic [31:0] merged;
  logic [31:0] pad_word;

  assign beat        = in_valid && in_ready;
  assign saturated   = (byte_count == 32'hffffffff);
  assign take_byte   = beat && has_byte && !saturated;
  assign count_after = take_byte ? byte_count + 32'd1 : byte_count;

  // First padding word: the bytes already held, the marker byte, then zeros.
  always_comb begin
    case (byte_count[1:0])
      2'd1:    merged = {acc[7:0], 8'h80, 16'h0};
      2'd2:    merged = {acc[15:0], 8'h80, 8'h0};
      2'd3:    merged = {acc[23:0], 8'h80};
      default: merged = 32'h80000000;
    endcase
  end

  always_comb begin
    if (len_here && pw == 4'd14) begin
      pad_word = {29'h0, byte_count[31:29]};
    end else if (len_here && pw == 4'd15) begin
      pad_word = {byte_count[28:0], 3'b000};
    end else if (pad_first) begin
      pad_word = merged;
    end else begin
      pad_word = 32'h0;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    push       = 1'b0;
    push_entry = '{msg_end: 1'b0, too_long: overflow, word: {acc, data_byte}};
    case (state)
      FR_ACCEPT: begin
        in_ready = !q_full;
        push     = take_byte && (byte_count[1:0] == 2'd3);
        if (beat && last) begin
          state_next = FR_PAD;
        end
      end
      FR_PAD: begin
        push       = !q_full;
        push_entry = '{msg_end: len_here && pw == 4'd15, too_long: overflow,
                       word: pad_word};
        if (!q_full && pw == 4'd15 && len_here) begin
          state_next = FR_ACCEPT;
        end
      end
      default: state_next = FR_ACCEPT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= FR_ACCEPT;
      byte_count <= 32'h0;
      overflow   <= 1'b0;
      pw         <= 4'd0;
      pad_first  <= 1'b0;
      len_here   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == FR_ACCEPT) begin
        if (take_byte) begin
          byte_count <= count_after;
          acc        <= {acc[15:0], data_byte};
        end
        if (beat && has_byte && saturated) begin
          overflow <= 1'b1;
        end
        if (beat && last) begin
          pad_first <= 1'b1;
          pw        <= count_after[5:2];
          len_here  <= (count_after[5:2] < 4'd14);
        end
      end else if (!q_full) begin
        pad_first <= 1'b0;
        pw        <= pw + 4'd1;
        if (pw == 4'd15) begin
          if (len_here) begin
            byte_count <= 32'h0;
            overflow   <= 1'b0;
          end else begin
            len_here <= 1'b1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ src/sha_queue.sv @@
// Small first-in first-out queue of message words between packer and compression engine.
`default_nettype none

module sha_queue
  import sha_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire q_entry_t push_entry,
  output logic          full,
  input  wire logic     pop,
  output q_entry_t      head,
  output logic          empty
);

  q_entry_t           entries [QDEPTH];
  logic [QAW-1:0]     wr_ptr;
  logic [QAW-1:0]     rd_ptr;
  logic [QCW-1:0]     count;

  assign full  = (count == QCW'(QDEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + QCW'(1);
        2'b01:   count <= count - QCW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/sha_back.sv @@
// Compression engine: 64 rounds per block, hash update and digest word output.
`default_nettype none

module sha_back
  import sha_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire q_entry_t head,
  input  wire logic     q_empty,
  output logic          pop,
  output logic          out_valid,
  input  wire logic     out_ready,
  output logic [31:0]   digest_word,
  output logic [2:0]    word_index,
  output logic          last_word,
  output logic          too_long
);

  function automatic logic [31:0] ror32(input logic [31:0] v, input logic [4:0] s);
    return (v >> s) | (v << (6'd32 - {1'b0, s}));
  endfunction

  back_state_t state, state_next;
  logic [5:0]  t;
  logic [2:0]  idx;
  logic        msg_end;
  logic        too_long_q;
  logic [31:0] hv    [8];
  logic [31:0] wv    [8];
  logic [31:0] sched [16];

  logic [31:0] src [8];
  logic        round_go;
  logic        early;
  logic [31:0] w_cur;
  logic [31:0] s0w, s1w, s0a, s1e, ch, maj, t1, t2;

  assign early = (t[5:4] == 2'b00);

  // Round zero starts from the chaining value, later rounds from the working set.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      src[i] = (t == 6'd0) ? hv[i] : wv[i];
    end
  end

  // Schedule: the shift line holds W[t-16] in entry 0 up to W[t-1] in entry 15.
  assign s0w   = ror32(sched[1], 5'd7) ^ ror32(sched[1], 5'd18) ^ (sched[1] >> 3);
  assign s1w   = ror32(sched[14], 5'd17) ^ ror32(sched[14], 5'd19) ^ (sched[14] >> 10);
  assign w_cur = early ? head.word : s1w + sched[9] + s0w + sched[0];

  assign s1e = ror32(src[4], 5'd6) ^ ror32(src[4], 5'd11) ^ ror32(src[4], 5'd25);
  assign ch  = (src[4] & src[5]) ^ (~src[4] & src[6]);
  assign s0a = ror32(src[0], 5'd2) ^ ror32(src[0], 5'd13) ^ ror32(src[0], 5'd22);
  assign maj = (src[0] & src[1]) ^ (src[0] & src[2]) ^ (src[1] & src[2]);
  assign t1  = src[7] + s1e + ch + round_k(t) + w_cur;
  assign t2  = s0a + maj;

  always_comb begin
    state_next = state;
    round_go   = 1'b0;
    pop        = 1'b0;
    out_valid  = 1'b0;
    case (state)
      BK_ROUND: begin
        round_go = !early || !q_empty;
        pop      = early && !q_empty;
        if (round_go && t == 6'd63) begin
          state_next = BK_ADD;
        end
      end
      BK_ADD: begin
        state_next = msg_end ? BK_OUT : BK_ROUND;
      end
      BK_OUT: begin
        out_valid = 1'b1;
        if (out_ready && idx == 3'd7) begin
          state_next = BK_ROUND;
        end
      end
      default: state_next = BK_ROUND;
    endcase
  end

  assign digest_word = hv[idx];
  assign word_index  = idx;
  assign last_word   = (idx == 3'd7);
  assign too_long    = too_long_q;

  always_ff @(posedge clk) begin
    if (round_go) begin
      wv[0] <= t1 + t2;
      wv[1] <= src[0];
      wv[2] <= src[1];
      wv[3] <= src[2];
      wv[4] <= src[3] + t1;
      wv[5] <= src[4];
      wv[6] <= src[5];
      wv[7] <= src[6];
      for (int i = 0; i < 15; i++) begin
        sched[i] <= sched[i+1];
      end
      sched[15] <= w_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_ROUND;
      t          <= 6'd0;
      idx        <= 3'd0;
      msg_end    <= 1'b0;
      too_long_q <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        hv[i] <= iv_word(3'(i));
      end
    end else begin
      state <= state_next;
      if (round_go) begin
        t <= t + 6'd1;
      end
      if (pop && head.msg_end) begin
        msg_end    <= 1'b1;
        too_long_q <= head.too_long;
      end
      if (state == BK_ADD) begin
        for (int i = 0; i < 8; i++) begin
          hv[i] <= hv[i] + wv[i];
        end
      end
      if (state == BK_OUT && out_ready) begin
        idx <= idx + 3'd1;
        if (idx == 3'd7) begin
          msg_end <= 1'b0;
          for (int i = 0; i < 8; i++) begin
            hv[i] <= iv_word(3'(i));
          end
        end
      end
    end
  end

  a_pop_early_rounds: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == BK_ROUND && early))
    else $error("queue popped outside the first sixteen rounds");

  a_end_goes_out: assert property (@(posedge clk) disable iff (rst)
    (state == BK_ADD && msg_end) |=> (state == BK_OUT && idx == 3'd0))
    else $error("final block did not lead to digest output");

  a_hash_reinit: assert property (@(posedge clk) disable iff (rst)
    (state == BK_OUT && out_ready && idx == 3'd7)
      |=> (hv[0] == iv_word(3'd0) && hv[7] == iv_word(3'd7) && t == 6'd0 && !msg_end))
    else $error("hash state not reinitialized after the digest");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == BK_OUT && !out_ready) |=> (state == BK_OUT && $stable(idx)))
    else $error("digest word changed while stalled");

endmodule

`default_nettype wire

@@ src/sha256_message_hasher_core.sv @@
// Top level of the streaming SHA-256 message hasher: packer, word queue and compression engine.
// Once the last padded word is queued while the engine waits for it, the first digest beat
// can be taken after the round that takes that word, 48 schedule rounds and the hash update.
// Throughput: one byte per beat; long messages run near one byte per cycle while the word
// queue has room, as the input is held off when it is full. Each message adds padding words,
// during which the input is held off, and 8 digest beats.
// Reset (rst, synchronous, active high) empties the queue, clears the byte count and the
// overflow flag and loads the SHA-256 initial hash values; no clearing pass is needed.
`default_nettype none

module sha256_message_hasher_core
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Input beats: one optional message byte, optionally ending the message.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tuser,   // [0] has_byte
  input  wire logic        s_tlast,   // last: ends the message
  // Output beats: eight digest words per message, most significant word first.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
  output logic             m_tuser,   // [0] too_long
  output logic             m_tlast    // last_word: set on the eighth digest word
);

  // The packer runs ahead of the compression engine; the word queue between them lets
  // the next block fill while the current one is being compressed.
  logic     push;
  q_entry_t push_entry;
  logic     q_full;
  logic     pop;
  q_entry_t head;
  logic     q_empty;

  logic [31:0] digest_word;
  logic [2:0]  word_index;

  sha_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .data_byte  (s_tdata),
    .has_byte   (s_tuser),
    .last       (s_tlast),
    .push       (push),
    .push_entry (push_entry),
    .q_full     (q_full)
  );

  sha_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty)
  );

  // The engine holds the finished digest in its chaining registers and presents one
  // word per output beat, so the output side may stall for any number of cycles.
  sha_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_empty     (q_empty),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (m_tlast),
    .too_long    (m_tuser)
  );

  assign m_tdata = {5'b00000, word_index, digest_word};

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for the streaming SHA-256 message hasher core.
`timescale 1ns / 100ps

module tb;

  // Clock, reset and run limits.
  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 7;
  localparam int RANDOM_ITEMS  = 170;
  localparam int IDLE_PERCENT  = 38;
  // The first digest beat follows the last padded word after the remaining rounds, and a
  // two-block padding tail adds one more compression, so the drain wait covers both.
  localparam int DRAIN_CYCLES  = 300;
  // No handshake on either side for this many cycles means the core has hung.
  localparam int HANG_LIMIT    = 4000;
  localparam int DIRECTED_ROWS = 15;
  // From this position in the block on, the length field no longer fits after the
  // 0x80 marker, so padding spills into a second block.
  localparam int LENGTH_SLOT   = 56;

  // Well-known digests of the empty message and of "abc".
  localparam logic [255:0] EMPTY_DIGEST =
    256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
  localparam logic [255:0] ABC_DIGEST =
    256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

  localparam logic [0:7][31:0] HASH_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] ROUND_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // One digest word as it should leave the core.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last_word;
    logic        too_long;
  } digest_beat_t;

  // One directed input beat; known marks rows whose digest is typed in.
  typedef struct packed {
    logic         has_byte;
    logic [7:0]   data;
    logic         last;
    logic         known;
    logic [255:0] digest;
  } stim_row_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tuser  = 1'b0;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  // While set, neither side inserts idle cycles.
  logic steady = 1'b0;

  int mismatches  = 0;
  int hang_cycles = 0;

  // Expected digest words, oldest first.
  digest_beat_t digest_words_due[$];

  // Predictor state: running hash, the block being filled, and the byte count.
  logic [31:0] hash_state [8];
  logic [7:0]  block_bytes [64];
  logic [31:0] bytes_taken;
  logic        count_saturated;

  // Directed part: empty message, "abc" with an idle beat inside it, messages that end
  // on a beat without a byte, the byte extremes, and idle beats between messages.
  // Data on beats without a byte is deliberately junk; the core must ignore it.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{1'b0, 8'h5a, 1'b1, 1'b1, EMPTY_DIGEST},
    '{1'b1, 8'h61, 1'b0, 1'b0, 256'h0},
    '{1'b1, 8'h62, 1'b0, 1'b0, 256'h0},
    '{1'b0, 8'hff, 1'b0, 1'b0, 256'h0},
    '{1'b1, 8'h63, 1'b1, 1'b1, ABC_DIGEST},
    '{1'b0, 8'h00, 1'b0, 1'b0, 256'h0},
    '{1'b1, 8'h00, 1'b0, 1'b0, 256'h0},
    '{1'b1, 8'hff, 1'b0, 1'b0, 256'h0},
    '{1'b0, 8'h33, 1'b1, 1'b0, 256'h0},
    '{1'b1, 8'hff, 1'b1, 1'b0, 256'h0},
    '{1'b1, 8'h80, 1'b0, 1'b0, 256'h0},
    '{1'b1, 8'h7f, 1'b0, 1'b0, 256'h0},
    '{1'b0, 8'h00, 1'b1, 1'b0, 256'h0},
    '{1'b0, 8'hcc, 1'b0, 1'b0, 256'h0},
    '{1'b0, 8'ha5, 1'b1, 1'b1, EMPTY_DIGEST}
  };

  sha256_message_hasher_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [7:0] data_byte
    .s_tuser  (s_tuser),   // [0] has_byte
    .s_tlast  (s_tlast),   // last
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [31:0] digest_word, [34:32] word_index, rest zero
    .m_tuser  (m_tuser),   // [0] too_long
    .m_tlast  (m_tlast)    // last_word
  );

  always #CLK_HALF clk = ~clk;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
    return (v >> s) | (v << (32 - s));
  endfunction

  // Returns the predictor to the state of a fresh message.
  function automatic void sha256_restart();
    int i;
    for (i = 0; i < 8; i++) hash_state[i] = HASH_INIT[i];
    for (i = 0; i < 64; i++) block_bytes[i] = 8'h00;
    bytes_taken     = 32'd0;
    count_saturated = 1'b0;
  endfunction

  // Runs the 64 rounds over block_bytes and folds the result into hash_state.
  function automatic void sha256_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    int t;
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (t = 0; t < 64; t++) begin
      if (t < 16) begin
        w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
      end else begin
        s0 = rotr(w[(t-15)%16], 7) ^ rotr(w[(t-15)%16], 18) ^ (w[(t-15)%16] >> 3);
        s1 = rotr(w[(t-2)%16], 17) ^ rotr(w[(t-2)%16], 19) ^ (w[(t-2)%16] >> 10);
        w[t%16] = w[t%16] + s0 + w[(t-7)%16] + s1;
      end
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + ROUND_K[t] + w[t%16];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endfunction

  // Takes one accepted input beat. Returns 1 when it closed a message, with the digest
  // and the overflow flag in the output arguments.
  function automatic bit sha256_absorb(input logic has_byte, input logic [7:0] data,
                                       input logic last, output logic [255:0] digest,
                                       output logic too_long);
    int pos;
    int i;
    logic [63:0] bit_len;
    digest = '0;
    if (has_byte) begin
      // A saturated count drops the byte and only remembers that it happened.
      if (bytes_taken == 32'hffff_ffff) begin
        count_saturated = 1'b1;
      end else begin
        block_bytes[bytes_taken[5:0]] = data;
        bytes_taken = bytes_taken + 32'd1;
        if (bytes_taken[5:0] == 6'd0) sha256_compress();
      end
    end
    too_long = count_saturated;
    if (!last) return 1'b0;
    pos = int'(bytes_taken[5:0]);
    block_bytes[pos] = 8'h80;
    for (i = pos + 1; i < 64; i++) block_bytes[i] = 8'h00;
    if (pos >= LENGTH_SLOT) begin
      sha256_compress();
      for (i = 0; i < LENGTH_SLOT; i++) block_bytes[i] = 8'h00;
    end
    bit_len = {29'd0, bytes_taken, 3'd0};
    for (i = 0; i < 8; i++) block_bytes[63 - i] = bit_len[8*i +: 8];
    sha256_compress();
    for (i = 0; i < 8; i++) digest[255 - 32*i -: 32] = hash_state[i];
    sha256_restart();
    return 1'b1;
  endfunction

  function automatic void queue_digest_words(input logic [255:0] digest, input logic too_long);
    int i;
    for (i = 0; i < 8; i++) begin
      digest_words_due.push_back('{word:      digest[255 - 32*i -: 32],
                                   index:     3'(i),
                                   last_word: (i == 7),
                                   too_long:  too_long});
    end
  endfunction

  // Presents one input beat, waits for it to be taken, then predicts its digest words.
  // A typed-in digest replaces the predicted one; the predictor still advances.
  task automatic send_item(input logic has_byte, input logic [7:0] data, input logic last,
                           input logic known = 1'b0, input logic [255:0] known_digest = '0);
    logic [255:0] digest;
    logic         too_long;
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= has_byte;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (sha256_absorb(has_byte, data, last, digest, too_long)) begin
      queue_digest_words(known ? known_digest : digest, too_long);
    end
  endtask

  // The receiver stalls at random, except during the steady stretch.
  always @(negedge clk) begin
    m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // Every accepted digest beat is compared with the oldest expected word.
  always @(posedge clk) begin : check_digest_beat
    digest_beat_t due;
    if (!rst && m_tvalid && m_tready) begin
      if (digest_words_due.size() == 0) begin
        $error("unexpected digest beat: tdata %h, tuser %b, tlast %b",
               m_tdata, m_tuser, m_tlast);
        mismatches++;
      end else begin
        due = digest_words_due.pop_front();
        if (m_tdata[31:0] !== due.word) begin
          $error("digest_word: expected %h, actual %h", due.word, m_tdata[31:0]);
          mismatches++;
        end
        if (m_tdata[34:32] !== due.index) begin
          $error("word_index: expected %0d, actual %0d", due.index, m_tdata[34:32]);
          mismatches++;
        end
        if (m_tlast !== due.last_word) begin
          $error("last_word: expected %b, actual %b", due.last_word, m_tlast);
          mismatches++;
        end
        if (m_tuser !== due.too_long) begin
          $error("too_long: expected %b, actual %b", due.too_long, m_tuser);
          mismatches++;
        end
      end
    end
  end

  // Hang detection: any beat on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      hang_cycles <= 0;
    end else if (hang_cycles >= HANG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      hang_cycles <= hang_cycles + 1;
    end
  end

  initial begin
    int r;
    int n;
    int random_items;
    int msg_num;
    int msg_len;
    logic tail_byte;

    sha256_restart();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (r = 0; r < DIRECTED_ROWS; r++) begin
      send_item(directed_rows[r].has_byte, directed_rows[r].data, directed_rows[r].last,
                directed_rows[r].known, directed_rows[r].digest);
    end

    // Random messages alternate between short ones and ones whose length sits on a
    // padding boundary: 55 bytes just fits the length in one block, 64 pads a fresh
    // empty block after a full one, and 56 pushes the length into a second block.
    // The fourth message runs with neither side idling; beats without a byte may still occur.
    random_items = 0;
    msg_num      = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (msg_num % 2 == 0) begin
        msg_len = $urandom_range(0, 9);
      end else begin
        case ((msg_num / 2) % 3)
          0:       msg_len = 55;
          1:       msg_len = 64;
          default: msg_len = 56;
        endcase
      end
      steady    = (msg_num == 3);
      tail_byte = (msg_len > 0) && ($urandom_range(0, 1) == 1);
      for (n = 0; n < msg_len; n++) begin
        // Occasional idle beat inside the message, with junk on the data lines.
        if ($urandom_range(0, 99) < 10) send_item(1'b0, 8'($urandom_range(0, 255)), 1'b0);
        send_item(1'b1, 8'($urandom_range(0, 255)), tail_byte && (n == msg_len - 1));
        random_items++;
      end
      // Otherwise the message is closed by a beat that carries no byte.
      if (!tail_byte) begin
        send_item(1'b0, 8'($urandom_range(0, 255)), 1'b1);
        random_items++;
      end
      msg_num++;
    end
    steady = 1'b0;

    @(negedge clk);
    s_tvalid <= 1'b0;

    while (digest_words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ sha256_message_hasher_core.f @@
src/sha_pkg.sv
src/sha_front.sv
src/sha_queue.sv
src/sha_back.sv
src/sha256_message_hasher_core.sv
tb/sv/tb.sv
